// ===== sv/dsvm_pkg.sv =====
`default_nettype none
package dsvm_pkg;

  localparam int VOICE_COUNT       = 5;
  localparam int SAMPLES_PER_VOICE = 16384;
  localparam int TRACK_SPAN        = 82;

  localparam int KIND_W      = 3;
  localparam int VOICE_W     = 3;
  localparam int TRACK_W     = 7;
  localparam int SAMPLE_W    = 16;
  localparam int LOAD_ADDR_W = 14;
  localparam int STATUS_W    = 2;
  localparam int VOL_W       = 8;
  localparam int LEN_W       = 15;
  localparam int POS_W       = $clog2(SAMPLES_PER_VOICE);
  localparam int VIDX_W      = $clog2(VOICE_COUNT + 1);

  localparam int STORE_DEPTH = VOICE_COUNT * SAMPLES_PER_VOICE;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  localparam int CFG_COUNT  = 7;
  localparam int REG_ADDR_W = $clog2(CFG_COUNT * 4);
  localparam int REG_IDX_W  = REG_ADDR_W - 2;

  localparam logic [VOL_W-1:0] VOL_MAX   = VOL_W'(200);
  localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(100);
  localparam int GAIN_DIV = 100;

  // seek position: track * length, then divide by the track span
  localparam int PROD_W       = TRACK_W + LEN_W;
  localparam int SEEK_SHIFT   = PROD_W + 8;
  localparam logic [63:0] SEEK_RECIP =
      ((64'd1 << SEEK_SHIFT) + 64'(TRACK_SPAN) - 64'd1) / 64'(TRACK_SPAN);
  localparam int SEEK_RECIP_W = SEEK_SHIFT + 1;
  localparam int SEEK_MUL_W   = PROD_W + SEEK_RECIP_W;

  // gain: sample * percent, then divide by 100 on the magnitude
  localparam int GAIN_PROD_W  = SAMPLE_W + VOL_W + 1;
  localparam int GAIN_MAG_W   = GAIN_PROD_W - 1;
  localparam int GAIN_SHIFT   = GAIN_MAG_W + 7;
  localparam logic [63:0] GAIN_RECIP =
      ((64'd1 << GAIN_SHIFT) + 64'(GAIN_DIV) - 64'd1) / 64'(GAIN_DIV);
  localparam int GAIN_RECIP_W = GAIN_SHIFT - 6;
  localparam int GAIN_MUL_W   = GAIN_MAG_W + GAIN_RECIP_W;
  localparam int GAIN_Q_W     = SAMPLE_W + 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAY      = 3'd0,
    KIND_STOP      = 3'd1,
    KIND_STOP_SEEK = 3'd2,
    KIND_STOP_ALL  = 3'd3,
    KIND_MIX       = 3'd4,
    KIND_LOAD      = 3'd5
  } kind_t;

  localparam logic [VOICE_W-1:0] VOICE_STARTUP   = 3'd0;
  localparam logic [VOICE_W-1:0] VOICE_CLICK     = 3'd1;
  localparam logic [VOICE_W-1:0] VOICE_SEEK_BACK = 3'd2;
  localparam logic [VOICE_W-1:0] VOICE_SEEK_FWD  = 3'd3;
  localparam logic [VOICE_W-1:0] VOICE_SPIN      = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DENIED    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_VOICE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ENABLED        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VOLUME         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEN_STARTUP    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LEN_CLICK      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LEN_SEEK_BACK  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEN_SEEK_FWD   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LEN_SPIN       = 3'd6;

  typedef struct packed {
    logic [6:0]             pad;
    logic [SAMPLE_W-1:0]    load_value;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [SAMPLE_W-1:0]    mix_right;
    logic [SAMPLE_W-1:0]    mix_left;
    logic                   stop_spin_too;
    logic [TRACK_W-1:0]     track;
    logic [VOICE_W-1:0]     voice;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]          pad;
    logic [SAMPLE_W-1:0] out_right;
    logic [SAMPLE_W-1:0] out_left;
    logic [STATUS_W-1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic                              enabled;
    logic [VOL_W-1:0]                  volume;
    logic [VOICE_COUNT-1:0][LEN_W-1:0] length;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic exec_simple;
    logic seek_mul;
    logic seek_div;
    logic seek_set;
    logic mix_read;
    logic mix_skip;
    logic mix_scale;
    logic mix_div;
    logic mix_acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              enabled;
    logic              voice_seek;
    logic              cur_playing;
    logic              last_voice;
    logic              out_free;
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEEK_DIV,
    ST_SEEK_SET,
    ST_MIX_READ,
    ST_MIX_SCALE,
    ST_MIX_DIV,
    ST_MIX_ACC,
    ST_DONE
  } state_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    if (raw == '0) eff_len = LEN_W'(1);
    else if (32'(raw) > SAMPLES_PER_VOICE) eff_len = LEN_W'(SAMPLES_PER_VOICE);
    else eff_len = raw;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_add(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W:0] t;
    t = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (t[SAMPLE_W] != t[SAMPLE_W-1]) begin
      sat_add = t[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat_add = t[SAMPLE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/dsvm_regs.sv =====
`default_nettype none
module dsvm_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dsvm_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output dsvm_pkg::cfg_t                       cfg
);

  logic [dsvm_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[dsvm_pkg::REG_ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled <= 1'b0;
      cfg.volume  <= dsvm_pkg::VOL_RESET;
      for (int i = 0; i < dsvm_pkg::VOICE_COUNT; i++) begin
        cfg.length[i] <= dsvm_pkg::LEN_W'(1);
      end
    end else if (wr) begin
      case (idx)
        dsvm_pkg::REG_ENABLED: cfg.enabled <= pwdata[0];
        dsvm_pkg::REG_VOLUME:  cfg.volume  <= pwdata[dsvm_pkg::VOL_W-1:0];
        dsvm_pkg::REG_LEN_STARTUP, dsvm_pkg::REG_LEN_CLICK, dsvm_pkg::REG_LEN_SEEK_BACK,
        dsvm_pkg::REG_LEN_SEEK_FWD, dsvm_pkg::REG_LEN_SPIN: begin
          cfg.length[3'(idx - dsvm_pkg::REG_LEN_STARTUP)] <= pwdata[dsvm_pkg::LEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dsvm_pkg::REG_ENABLED: prdata = 32'(cfg.enabled);
      dsvm_pkg::REG_VOLUME:  prdata = 32'(cfg.volume);
      dsvm_pkg::REG_LEN_STARTUP, dsvm_pkg::REG_LEN_CLICK, dsvm_pkg::REG_LEN_SEEK_BACK,
      dsvm_pkg::REG_LEN_SEEK_FWD, dsvm_pkg::REG_LEN_SPIN: begin
        prdata = 32'(cfg.length[3'(idx - dsvm_pkg::REG_LEN_STARTUP)]);
      end
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/dsvm_store.sv =====
`default_nettype none
module dsvm_store (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [dsvm_pkg::STORE_AW-1:0] waddr,
  input  wire logic [dsvm_pkg::SAMPLE_W-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [dsvm_pkg::STORE_AW-1:0] raddr,
  output logic      [dsvm_pkg::SAMPLE_W-1:0] rdata
);

  logic [dsvm_pkg::SAMPLE_W-1:0] mem [dsvm_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/dsvm_datapath.sv =====
`default_nettype none
module dsvm_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire dsvm_pkg::cfg_t                  cfg,
  input  wire dsvm_pkg::cmd_t                  cmd,
  output dsvm_pkg::stat_t                      stat,
  input  wire logic [dsvm_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [dsvm_pkg::KIND_W-1:0]     s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [dsvm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                                 store_we,
  output logic      [dsvm_pkg::STORE_AW-1:0]   store_waddr,
  output logic      [dsvm_pkg::SAMPLE_W-1:0]   store_wdata,
  output logic                                 store_re,
  output logic      [dsvm_pkg::STORE_AW-1:0]   store_raddr,
  input  wire logic [dsvm_pkg::SAMPLE_W-1:0]   store_rdata
);

  localparam int SW = dsvm_pkg::SAMPLE_W;
  localparam int LW = dsvm_pkg::LEN_W;
  localparam int PW = dsvm_pkg::PROD_W;

  // item and mix accumulators
  dsvm_pkg::in_beat_t             item;
  logic [dsvm_pkg::KIND_W-1:0]    kind;
  logic [SW-1:0]                  acc_left;
  logic [SW-1:0]                  acc_right;
  logic [dsvm_pkg::STATUS_W-1:0]  status_q;

  // voice state
  logic [dsvm_pkg::VOICE_COUNT-1:0] playing;
  logic [dsvm_pkg::POS_W-1:0]       position [dsvm_pkg::VOICE_COUNT];
  logic [dsvm_pkg::VIDX_W-1:0]      vidx;

  // arithmetic stages
  logic [PW-1:0]                      seek_prod;
  logic [PW-1:0]                      seek_q;
  logic [dsvm_pkg::POS_W-1:0]         cur_pos;
  logic [dsvm_pkg::GAIN_PROD_W-1:0]   gain_prod;
  logic                               gain_neg;
  logic [dsvm_pkg::GAIN_Q_W-1:0]      gain_q;

  // result register
  dsvm_pkg::out_beat_t out_q;
  logic                out_valid;

  logic                              voice_ok;
  logic                              vidx_ok;
  logic                              seek_back;
  logic [dsvm_pkg::VOL_W-1:0]        vol_eff;
  logic [dsvm_pkg::VOICE_W-1:0]      lsel;
  logic [LW-1:0]                     len_raw;
  logic [LW-1:0]                     len;
  logic [LW-1:0]                     len_m1;
  logic [dsvm_pkg::POS_W-1:0]        pos_sel;
  logic [dsvm_pkg::POS_W-1:0]        mix_cur;
  logic [LW-1:0]                     mix_nxt;
  logic                              mix_wrap;
  logic [PW-1:0]                     seek_num;
  logic [dsvm_pkg::SEEK_MUL_W-1:0]   seek_mul;
  logic [LW-1:0]                     seek_tmp;
  logic [LW-1:0]                     seek_pos;
  logic [dsvm_pkg::GAIN_PROD_W-1:0]  gain_abs;
  logic [dsvm_pkg::GAIN_MUL_W-1:0]   gain_mul;
  logic [dsvm_pkg::GAIN_Q_W-1:0]     gain_q_neg;
  logic [SW-1:0]                     scaled;
  logic [dsvm_pkg::STATUS_W-1:0]     simple_status;

  assign voice_ok  = item.voice < dsvm_pkg::VOICE_W'(dsvm_pkg::VOICE_COUNT);
  assign vidx_ok   = vidx < dsvm_pkg::VIDX_W'(dsvm_pkg::VOICE_COUNT);
  assign seek_back = item.voice == dsvm_pkg::VOICE_SEEK_BACK;
  assign vol_eff   = (cfg.volume > dsvm_pkg::VOL_MAX) ? dsvm_pkg::VOL_MAX : cfg.volume;

  // one length select, shared by the seek and mix paths
  assign lsel    = (kind == dsvm_pkg::KIND_MIX) ? dsvm_pkg::VOICE_W'(vidx) : item.voice;
  assign len_raw = (lsel < dsvm_pkg::VOICE_W'(dsvm_pkg::VOICE_COUNT)) ? cfg.length[lsel]
                                                                       : LW'(1);
  assign len     = dsvm_pkg::eff_len(len_raw);
  assign len_m1  = len - LW'(1);

  assign pos_sel  = vidx_ok ? position[vidx] : '0;
  assign mix_cur  = (LW'(pos_sel) >= len) ? '0 : pos_sel;
  assign mix_nxt  = LW'(cur_pos) + LW'(1);
  assign mix_wrap = mix_nxt >= len;

  assign seek_num = seek_prod + (seek_back ? PW'(dsvm_pkg::TRACK_SPAN - 1) : '0);
  assign seek_mul = dsvm_pkg::SEEK_MUL_W'(seek_num) *
                    dsvm_pkg::SEEK_MUL_W'(dsvm_pkg::SEEK_RECIP);

  always_comb begin
    seek_tmp = (seek_q >= PW'(len)) ? '0 : len - LW'(seek_q);
    if (seek_back) begin
      seek_pos = (seek_tmp > len_m1) ? len_m1 : seek_tmp;
    end else begin
      seek_pos = (seek_q > PW'(len_m1)) ? len_m1 : LW'(seek_q);
    end
  end

  assign gain_abs = gain_prod[dsvm_pkg::GAIN_PROD_W-1] ? (~gain_prod + 1'b1) : gain_prod;
  assign gain_mul = dsvm_pkg::GAIN_MUL_W'(gain_abs[dsvm_pkg::GAIN_MAG_W-1:0]) *
                    dsvm_pkg::GAIN_MUL_W'(dsvm_pkg::GAIN_RECIP);
  assign gain_q_neg = ~gain_q + 1'b1;

  // saturate the scaled sample to 16 bits
  always_comb begin
    if (!gain_neg) begin
      scaled = (gain_q > dsvm_pkg::GAIN_Q_W'(2**(SW-1) - 1)) ? {1'b0, {(SW-1){1'b1}}}
                                                               : gain_q[SW-1:0];
    end else begin
      scaled = (gain_q > dsvm_pkg::GAIN_Q_W'(2**(SW-1))) ? {1'b1, {(SW-1){1'b0}}}
                                                           : gain_q_neg[SW-1:0];
    end
  end

  always_comb begin
    if (kind == dsvm_pkg::KIND_LOAD) begin
      simple_status = voice_ok ? dsvm_pkg::STATUS_OK : dsvm_pkg::STATUS_BAD_VOICE;
    end else if (kind <= dsvm_pkg::KIND_W'(dsvm_pkg::KIND_MIX) && !cfg.enabled) begin
      simple_status = dsvm_pkg::STATUS_DENIED;
    end else if ((kind == dsvm_pkg::KIND_PLAY || kind == dsvm_pkg::KIND_STOP) && !voice_ok) begin
      simple_status = dsvm_pkg::STATUS_BAD_VOICE;
    end else begin
      simple_status = dsvm_pkg::STATUS_OK;
    end
  end

  assign store_we    = cmd.exec_simple && kind == dsvm_pkg::KIND_LOAD && voice_ok &&
                       32'(item.load_address) < dsvm_pkg::SAMPLES_PER_VOICE;
  assign store_waddr = dsvm_pkg::STORE_AW'(item.voice) *
                       dsvm_pkg::STORE_AW'(dsvm_pkg::SAMPLES_PER_VOICE) +
                       dsvm_pkg::STORE_AW'(item.load_address);
  assign store_wdata = item.load_value;
  assign store_re    = cmd.mix_read;
  assign store_raddr = dsvm_pkg::STORE_AW'(vidx) *
                       dsvm_pkg::STORE_AW'(dsvm_pkg::SAMPLES_PER_VOICE) +
                       dsvm_pkg::STORE_AW'(mix_cur);

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item      <= dsvm_pkg::in_beat_t'(s_tdata);
      kind      <= s_tuser;
      acc_left  <= s_tdata[26:11];
      acc_right <= s_tdata[42:27];
      status_q  <= dsvm_pkg::STATUS_OK;
    end
    if (cmd.exec_simple) status_q <= simple_status;
    if (cmd.seek_mul) seek_prod <= PW'(item.track) * PW'(len);
    if (cmd.seek_div) seek_q <= seek_mul[dsvm_pkg::SEEK_SHIFT +: PW];
    if (cmd.mix_read) cur_pos <= mix_cur;
    if (cmd.mix_scale) gain_prod <= $signed(store_rdata) * $signed({1'b0, vol_eff});
    if (cmd.mix_div) begin
      gain_q   <= gain_mul[dsvm_pkg::GAIN_SHIFT +: dsvm_pkg::GAIN_Q_W];
      gain_neg <= gain_prod[dsvm_pkg::GAIN_PROD_W-1];
    end
    if (cmd.mix_acc) begin
      acc_left  <= dsvm_pkg::sat_add(acc_left, scaled);
      acc_right <= dsvm_pkg::sat_add(acc_right, scaled);
    end
    if (cmd.out_load) begin
      out_q.pad       <= '0;
      out_q.status    <= status_q;
      out_q.out_left  <= acc_left;
      out_q.out_right <= acc_right;
    end
  end

  // voice state and mix voice counter
  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= '0;
      vidx    <= '0;
      for (int i = 0; i < dsvm_pkg::VOICE_COUNT; i++) position[i] <= '0;
    end else begin
      if (cmd.take) vidx <= '0;
      if (cmd.exec_simple && simple_status == dsvm_pkg::STATUS_OK) begin
        case (kind)
          dsvm_pkg::KIND_PLAY: begin
            if (!(item.voice == dsvm_pkg::VOICE_SPIN && playing[dsvm_pkg::VOICE_SPIN])) begin
              playing[item.voice]  <= 1'b1;
              position[item.voice] <= '0;
            end
          end
          dsvm_pkg::KIND_STOP: playing[item.voice] <= 1'b0;
          dsvm_pkg::KIND_STOP_SEEK: begin
            playing[dsvm_pkg::VOICE_SEEK_BACK] <= 1'b0;
            playing[dsvm_pkg::VOICE_SEEK_FWD]  <= 1'b0;
          end
          dsvm_pkg::KIND_STOP_ALL: begin
            playing[dsvm_pkg::VOICE_STARTUP]   <= 1'b0;
            playing[dsvm_pkg::VOICE_CLICK]     <= 1'b0;
            playing[dsvm_pkg::VOICE_SEEK_BACK] <= 1'b0;
            playing[dsvm_pkg::VOICE_SEEK_FWD]  <= 1'b0;
            if (item.stop_spin_too) playing[dsvm_pkg::VOICE_SPIN] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.seek_set) begin
        position[item.voice] <= seek_pos[dsvm_pkg::POS_W-1:0];
        playing[item.voice]  <= 1'b1;
        if (seek_back) playing[dsvm_pkg::VOICE_SEEK_FWD] <= 1'b0;
        else playing[dsvm_pkg::VOICE_SEEK_BACK] <= 1'b0;
      end
      if (cmd.mix_skip) vidx <= vidx + 1'b1;
      if (cmd.mix_acc) begin
        position[vidx] <= mix_wrap ? '0 : mix_nxt[dsvm_pkg::POS_W-1:0];
        if (mix_wrap && vidx != dsvm_pkg::VIDX_W'(dsvm_pkg::VOICE_SPIN)) playing[vidx] <= 1'b0;
        vidx <= vidx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_q;

  assign stat.kind        = kind;
  assign stat.enabled     = cfg.enabled;
  assign stat.voice_seek  = item.voice == dsvm_pkg::VOICE_SEEK_BACK ||
                            item.voice == dsvm_pkg::VOICE_SEEK_FWD;
  assign stat.cur_playing = vidx_ok && playing[vidx];
  assign stat.last_voice  = vidx == dsvm_pkg::VIDX_W'(dsvm_pkg::VOICE_COUNT - 1);
  assign stat.out_free    = !out_valid || m_tready;

endmodule
`default_nettype wire

// ===== sv/dsvm_ctrl.sv =====
`default_nettype none
module dsvm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire dsvm_pkg::stat_t stat,
  output dsvm_pkg::cmd_t       cmd
);

  dsvm_pkg::state_t state;
  dsvm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= dsvm_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = state == dsvm_pkg::ST_IDLE;
    case (state)
      dsvm_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = dsvm_pkg::ST_DECODE;
        end
      end
      dsvm_pkg::ST_DECODE: begin
        if (stat.enabled && stat.kind == dsvm_pkg::KIND_PLAY && stat.voice_seek) begin
          cmd.seek_mul = 1'b1;
          state_next   = dsvm_pkg::ST_SEEK_DIV;
        end else if (stat.enabled && stat.kind == dsvm_pkg::KIND_MIX) begin
          state_next = dsvm_pkg::ST_MIX_READ;
        end else begin
          cmd.exec_simple = 1'b1;
          state_next      = dsvm_pkg::ST_DONE;
        end
      end
      dsvm_pkg::ST_SEEK_DIV: begin
        cmd.seek_div = 1'b1;
        state_next   = dsvm_pkg::ST_SEEK_SET;
      end
      dsvm_pkg::ST_SEEK_SET: begin
        cmd.seek_set = 1'b1;
        state_next   = dsvm_pkg::ST_DONE;
      end
      dsvm_pkg::ST_MIX_READ: begin
        if (stat.cur_playing) begin
          cmd.mix_read = 1'b1;
          state_next   = dsvm_pkg::ST_MIX_SCALE;
        end else if (stat.last_voice) begin
          state_next = dsvm_pkg::ST_DONE;
        end else begin
          cmd.mix_skip = 1'b1;
        end
      end
      dsvm_pkg::ST_MIX_SCALE: begin
        cmd.mix_scale = 1'b1;
        state_next    = dsvm_pkg::ST_MIX_DIV;
      end
      dsvm_pkg::ST_MIX_DIV: begin
        cmd.mix_div = 1'b1;
        state_next  = dsvm_pkg::ST_MIX_ACC;
      end
      dsvm_pkg::ST_MIX_ACC: begin
        cmd.mix_acc = 1'b1;
        state_next  = stat.last_voice ? dsvm_pkg::ST_DONE : dsvm_pkg::ST_MIX_READ;
      end
      dsvm_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = dsvm_pkg::ST_IDLE;
        end
      end
      default: state_next = dsvm_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/drive_sound_voice_mixer.sv =====
// Each beat is taken in idle and decoded, then waits in done for a free result register:
// play, stop, stop seek, stop all, load go straight to done; seek play divides, then sets;
// mix: read, scale, divide, add per playing voice (one shared sample memory read port).
// m_tvalid rises the cycle after the load; the next beat is taken while the result waits.
// rst (synchronous, high) clears voice state, the controller and the result valid flag and
// loads register defaults; sample memory keeps its contents and needs no clearing pass.
`default_nettype none
module drive_sound_voice_mixer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // s_tdata fields from bit 0: voice[3], track[7], stop_spin_too[1], mix_left[16],
  // mix_right[16], load_address[14], load_value[16], zero pad[7]
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [dsvm_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser fields from bit 0: kind[3]
  input  wire logic [dsvm_pkg::KIND_W-1:0]     s_tuser,
  // m_tdata fields from bit 0: status[2], out_left[16], out_right[16], zero pad[6]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [dsvm_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dsvm_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  dsvm_pkg::cfg_t  cfg;
  dsvm_pkg::cmd_t  cmd;
  dsvm_pkg::stat_t stat;

  logic                          store_we;
  logic [dsvm_pkg::STORE_AW-1:0] store_waddr;
  logic [dsvm_pkg::SAMPLE_W-1:0] store_wdata;
  logic                          store_re;
  logic [dsvm_pkg::STORE_AW-1:0] store_raddr;
  logic [dsvm_pkg::SAMPLE_W-1:0] store_rdata;

  // register file behind the APB port
  dsvm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // five voices of PCM, one region per voice, one write and one registered read port
  dsvm_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // sequencer: decode the beat, step seek math or walk the voices one at a time
  dsvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // voice state, seek divider, gain multiply/divide, saturating mix, result register
  dsvm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .store_we    (store_we),
    .store_waddr (store_waddr),
    .store_wdata (store_wdata),
    .store_re    (store_re),
    .store_raddr (store_raddr),
    .store_rdata (store_rdata)
  );

endmodule
`default_nettype wire

// ===== sv/dsvm_checker.sv =====
`default_nettype none
module dsvm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [dsvm_pkg::IN_DATA_W-1:0]  s_tdata,
  input wire logic [dsvm_pkg::KIND_W-1:0]     s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [dsvm_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                            psel,
  input wire logic                            penable,
  input wire logic                            pwrite,
  input wire logic [dsvm_pkg::REG_ADDR_W-1:0] paddr,
  input wire logic [31:0]                     pwdata,
  input wire logic [31:0]                     prdata,
  input wire logic                            pready
);

  // the block works one beat at a time: no accept right after an accept
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a beat is in decode");

  // a result never appears in the cycle right after an accept unless it was already waiting
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("result produced without any work cycles");

  // status code is one of ok, not allowed, invalid voice
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("undefined status code");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind drive_sound_voice_mixer dsvm_checker u_dsvm_checker (.*);
`default_nettype wire

// ===== tb/tb_drive_sound_voice_mixer.sv =====
module tb_drive_sound_voice_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  import dsvm_pkg::*;

  // Software mirror of the mixer: voice state, registers and sample memory.
  // It works out the result owed for every accepted command beat.
  class voice_mixer_mirror;
    bit              enabled;
    bit [VOL_W-1:0]  volume;
    bit [LEN_W-1:0]  len_reg [VOICE_COUNT];
    bit              playing [VOICE_COUNT];
    int unsigned     position [VOICE_COUNT];
    shortint         sample_mem [STORE_DEPTH];
    bit              written [STORE_DEPTH];
    out_beat_t       owed_results [$];
    int              errors;

    function new();
      enabled = 1'b0;
      volume  = VOL_RESET;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        len_reg[i]  = LEN_W'(1);
        playing[i]  = 1'b0;
        position[i] = 0;
      end
      errors = 0;
    endfunction

    function int sat16(int x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
    endfunction

    function int unsigned eff_length(int v);
      int unsigned l;
      l = len_reg[v];
      if (l == 0) l = 1;
      if (l > SAMPLES_PER_VOICE) l = SAMPLES_PER_VOICE;
      return l;
    endfunction

    // A length change can leave a voice past its end; it then restarts at zero.
    function int unsigned read_pos(int v);
      int unsigned p;
      p = position[v];
      if (p >= eff_length(v)) p = 0;
      return p;
    endfunction

    function bit needs_load(int v);
      return enabled && playing[v] && !written[v * SAMPLES_PER_VOICE + read_pos(v)];
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
      if (idx == REG_ENABLED) enabled = val[0];
      else if (idx == REG_VOLUME) volume = val[VOL_W-1:0];
      else if (idx < CFG_COUNT) len_reg[idx - REG_LEN_STARTUP] = val[LEN_W-1:0];
    endfunction

    function void take_command(logic [KIND_W-1:0] kind, in_beat_t d);
      int unsigned voice, track, addr, l, prod, pos, c;
      int left, right, s, vol, i;
      logic [STATUS_W-1:0] status;
      out_beat_t r;
      voice  = d.voice;
      track  = d.track;
      addr   = d.load_address;
      left   = $signed(d.mix_left);
      right  = $signed(d.mix_right);
      status = STATUS_OK;
      if (kind == KIND_LOAD) begin
        if (voice >= VOICE_COUNT) begin
          status = STATUS_BAD_VOICE;
        end else if (addr < SAMPLES_PER_VOICE) begin
          sample_mem[voice * SAMPLES_PER_VOICE + addr] = d.load_value;
          written[voice * SAMPLES_PER_VOICE + addr] = 1'b1;
        end
      end else if (kind > KIND_LOAD) begin
        // unknown kinds pass through untouched
      end else if (!enabled) begin
        status = STATUS_DENIED;
      end else begin
        case (kind)
          KIND_PLAY: begin
            if (voice >= VOICE_COUNT) begin
              status = STATUS_BAD_VOICE;
            end else if (voice == VOICE_SEEK_BACK || voice == VOICE_SEEK_FWD) begin
              l = eff_length(voice);
              prod = track * l;
              if (voice == VOICE_SEEK_FWD) begin
                pos = prod / TRACK_SPAN;
                if (pos > l - 1) pos = l - 1;
                playing[VOICE_SEEK_BACK] = 1'b0;
              end else begin
                c = (prod + TRACK_SPAN - 1) / TRACK_SPAN;
                pos = (c >= l) ? 0 : l - c;
                if (pos > l - 1) pos = l - 1;
                playing[VOICE_SEEK_FWD] = 1'b0;
              end
              position[voice] = pos;
              playing[voice] = 1'b1;
            end else if (!(voice == VOICE_SPIN && playing[VOICE_SPIN])) begin
              playing[voice] = 1'b1;
              position[voice] = 0;
            end
          end
          KIND_STOP: begin
            if (voice >= VOICE_COUNT) status = STATUS_BAD_VOICE;
            else playing[voice] = 1'b0;
          end
          KIND_STOP_SEEK: begin
            playing[VOICE_SEEK_BACK] = 1'b0;
            playing[VOICE_SEEK_FWD] = 1'b0;
          end
          KIND_STOP_ALL: begin
            for (i = 0; i < VOICE_COUNT; i++)
              if (i != VOICE_SPIN || d.stop_spin_too) playing[i] = 1'b0;
          end
          default: begin
            vol = (volume > VOL_MAX) ? VOL_MAX : volume;
            for (i = 0; i < VOICE_COUNT; i++) begin
              if (playing[i]) begin
                l = eff_length(i);
                pos = read_pos(i);
                s = sample_mem[i * SAMPLES_PER_VOICE + pos];
                s = sat16((s * vol) / GAIN_DIV);
                left = sat16(left + s);
                right = sat16(right + s);
                pos++;
                if (pos >= l) begin
                  pos = 0;
                  if (i != VOICE_SPIN) playing[i] = 1'b0;
                end
                position[i] = pos;
              end
            end
          end
        endcase
      end
      r = '0;
      r.status = status;
      r.out_left = left[SAMPLE_W-1:0];
      r.out_right = right[SAMPLE_W-1:0];
      owed_results.push_back(r);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: result beat with nothing owed: %h", $time, got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.out_left !== want.out_left) begin
        $display("%0t: out_left expected %h got %h", $time, want.out_left, got.out_left);
        errors++;
      end
      if (got.out_right !== want.out_right) begin
        $display("%0t: out_right expected %h got %h", $time, want.out_right, got.out_right);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata;
  logic [KIND_W-1:0]       s_tuser;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [REG_ADDR_W-1:0]   paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  voice_mixer_mirror tracker;
  // set during stretches where neither side idles
  bit calm;

  drive_sound_voice_mixer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run, counting worst stalls and mixes.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Favor the saturation corners of a 16-bit sample.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  // Fill every field so each bit toggles, whatever the command uses.
  function automatic in_beat_t random_fields();
    in_beat_t d;
    d = '0;
    d.voice         = ($urandom_range(0, 9) == 0) ?
                      VOICE_W'(VOICE_SPIN + $urandom_range(1, 3)) :
                      VOICE_W'($urandom_range(0, VOICE_COUNT - 1));
    d.track         = TRACK_W'($urandom_range(0, 127));
    d.stop_spin_too = $urandom_range(0, 1);
    d.mix_left      = rand_sample();
    d.mix_right     = rand_sample();
    d.load_address  = LOAD_ADDR_W'($urandom_range(0, SAMPLES_PER_VOICE - 1));
    d.load_value    = rand_sample();
    return d;
  endfunction

  // Result side: hold ready high for a burst, then drop it for a random gap.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      int unsigned gap;
      m_tready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Watch both streams at the rising edge: note each command beat, check each result beat.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) tracker.take_command(s_tuser, in_beat_t'(s_tdata));
    if (!rst && m_tvalid && m_tready) tracker.check_result(out_beat_t'(m_tdata));
  end

  // Drive one command beat, starting and ending at a falling edge.
  // Valid stays high into the next beat unless a gap is drawn.
  task automatic push_beat(input logic [KIND_W-1:0] kind, input in_beat_t d);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  = kind;
    s_tdata  = d;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Send a command; ahead of a mix, load any sample a playing voice is about
  // to read that has never been written.
  task automatic send_item(input logic [KIND_W-1:0] kind, input in_beat_t d);
    in_beat_t pre;
    int v;
    if (kind == KIND_MIX) begin
      for (v = 0; v < VOICE_COUNT; v++) begin
        if (tracker.needs_load(v)) begin
          pre = random_fields();
          pre.voice = VOICE_W'(v);
          pre.load_address = LOAD_ADDR_W'(tracker.read_pos(v));
          push_beat(KIND_LOAD, pre);
        end
      end
    end
    push_beat(kind, d);
  endtask

  // Directed command; extreme pins the frame and load fields to their corners.
  task automatic cmd(input logic [KIND_W-1:0] kind, input logic [VOICE_W-1:0] voice,
                     input int unsigned track, input bit spin, input bit extreme);
    in_beat_t d;
    d = random_fields();
    d.voice = voice;
    d.track = TRACK_W'(track);
    d.stop_spin_too = spin;
    if (extreme) begin
      d.mix_left     = 16'h7fff;
      d.mix_right    = 16'h8000;
      d.load_address = LOAD_ADDR_W'(SAMPLES_PER_VOICE - 1);
      d.load_value   = 16'h8000;
    end
    send_item(kind, d);
  endtask

  // Wait out every owed result, then a few more cycles for the block to settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tracker.owed_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reprogram every register with the block idle; lengths drawn from lo..hi.
  task automatic configure(input bit en, input int unsigned vol,
                           input int unsigned lo, input int unsigned hi);
    int k;
    drain();
    apb_write(REG_ENABLED, en);
    apb_write(REG_VOLUME, vol);
    for (k = 0; k < VOICE_COUNT; k++)
      apb_write(REG_IDX_W'(REG_LEN_STARTUP + k), $urandom_range(hi, lo));
  endtask

  // Random commands: mostly mixes and plays so voices run deep, with some stops,
  // loads, bad voices and unknown kinds mixed in.
  task automatic run_random(input int count);
    logic [KIND_W-1:0] kind;
    in_beat_t d;
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) kind = KIND_MIX;
      else if (r < 62) kind = KIND_PLAY;
      else if (r < 76) kind = KIND_LOAD;
      else if (r < 84) kind = KIND_STOP;
      else if (r < 89) kind = KIND_STOP_SEEK;
      else if (r < 94) kind = KIND_STOP_ALL;
      else kind = KIND_W'(KIND_LOAD + $urandom_range(1, 2));
      d = random_fields();
      if (kind == KIND_LOAD && $urandom_range(0, 1))
        d.load_address = LOAD_ADDR_W'($urandom_range(0, 63));
      // pause now and then until every owed result is back
      if ($urandom_range(0, 199) == 0) drain();
      send_item(kind, d);
    end
  endtask

  initial begin
    tracker  = new;
    calm     = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset state is disabled: commands are refused, loads and unknown kinds still pass.
    cmd(KIND_PLAY, VOICE_STARTUP, 0, 1'b0, 1'b0);
    cmd(KIND_MIX, VOICE_STARTUP, 0, 1'b0, 1'b1);
    cmd(KIND_LOAD, VOICE_SPIN, 0, 1'b0, 1'b1);
    cmd(KIND_LOAD, VOICE_W'(VOICE_SPIN + 3), 0, 1'b0, 1'b0);
    cmd(KIND_W'(KIND_LOAD + 2), VOICE_STARTUP, 0, 1'b0, 1'b0);

    // Enable with short voices and walk through every command and corner.
    configure(1'b1, VOL_RESET, 2, 6);
    cmd(KIND_PLAY, VOICE_STARTUP, 0, 1'b0, 1'b0);
    cmd(KIND_PLAY, VOICE_SPIN, 0, 1'b0, 1'b0);
    cmd(KIND_MIX, VOICE_STARTUP, 0, 1'b0, 1'b1);
    // spin already running: must not restart
    cmd(KIND_PLAY, VOICE_SPIN, 0, 1'b0, 1'b0);
    cmd(KIND_PLAY, VOICE_SEEK_BACK, 0, 1'b0, 1'b0);
    // forward seek at the top track knocks out the back seek
    cmd(KIND_PLAY, VOICE_SEEK_FWD, 127, 1'b0, 1'b0);
    cmd(KIND_MIX, VOICE_STARTUP, 0, 1'b0, 1'b0);
    cmd(KIND_PLAY, VOICE_SEEK_BACK, 127, 1'b0, 1'b0);
    cmd(KIND_PLAY, VOICE_SEEK_FWD, 0, 1'b0, 1'b0);
    cmd(KIND_PLAY, VOICE_CLICK, 0, 1'b0, 1'b0);
    cmd(KIND_MIX, VOICE_STARTUP, 0, 1'b0, 1'b1);
    cmd(KIND_PLAY, VOICE_W'(VOICE_SPIN + 1), 0, 1'b0, 1'b0);
    cmd(KIND_STOP, VOICE_W'(VOICE_SPIN + 3), 0, 1'b0, 1'b0);
    cmd(KIND_STOP, VOICE_CLICK, 0, 1'b0, 1'b0);
    cmd(KIND_STOP_SEEK, VOICE_STARTUP, 0, 1'b0, 1'b0);
    cmd(KIND_MIX, VOICE_STARTUP, 0, 1'b0, 1'b0);
    // stop all, first sparing spin, then including it
    cmd(KIND_STOP_ALL, VOICE_STARTUP, 0, 1'b0, 1'b0);
    cmd(KIND_MIX, VOICE_STARTUP, 0, 1'b0, 1'b0);
    cmd(KIND_STOP_ALL, VOICE_STARTUP, 0, 1'b1, 1'b0);
    cmd(KIND_MIX, VOICE_STARTUP, 0, 1'b0, 1'b1);
    cmd(KIND_W'(KIND_LOAD + 1), VOICE_STARTUP, 0, 1'b0, 1'b0);

    // Random phases over a spread of settings.
    configure(1'b1, VOL_RESET, 1, 12);
    run_random(300);

    // Double gain, one-sample voices; a zero length acts as one.
    configure(1'b1, VOL_MAX, 1, 1);
    apb_write(REG_LEN_STARTUP, 0);
    run_random(150);

    // Gain beyond the clamp, longest voices; oversize lengths act as the maximum.
    configure(1'b1, 255, SAMPLES_PER_VOICE, 32767);
    apb_write(REG_LEN_SPIN, 32767);
    apb_write(REG_LEN_SEEK_FWD, SAMPLES_PER_VOICE);
    run_random(100);

    // Silent gain.
    configure(1'b1, 0, 1, 40);
    run_random(200);

    // Disabled with voices left playing: everything but loads and unknown kinds is refused.
    configure(1'b0, VOL_RESET, 1, 8);
    run_random(60);

    // Random gain, no idling on either side.
    configure(1'b1, $urandom_range(0, 255), 1, 64);
    calm = 1'b1;
    run_random(300);
    calm = 1'b0;

    // Smallest nonzero gain.
    configure(1'b1, 1, 1, 24);
    run_random(300);

    drain();
    s_tvalid = 1'b0;
    repeat (30) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/dsvm_pkg.sv
sv/dsvm_regs.sv
sv/dsvm_store.sv
sv/dsvm_datapath.sv
sv/dsvm_ctrl.sv
sv/drive_sound_voice_mixer.sv
sv/dsvm_checker.sv
tb/tb_drive_sound_voice_mixer.sv
